>>> rtl/xbrs_pkg.sv
// Shared types, constants and the xorshift step for the bounded random source.
`timescale 1ns / 1ps
package xbrs_pkg;

   localparam int unsigned ACTION_W = 2;
   localparam int unsigned BOUND_W  = 32;
   localparam int unsigned WORD_W   = 64;
   localparam int unsigned HALF_W   = 32;

   localparam logic [WORD_W-1:0] RESET_STATE   = 64'h0DEA_DCA7_FEED_BEEF;
   localparam logic [WORD_W-1:0] SEED_FALLBACK = 64'hCAFE_BABE_DEAD_BEEF;
   localparam logic [WORD_W-1:0] SCRAMBLE_MUL  = 64'h2545_F491_4F6C_DD1D;

   localparam int unsigned SHIFT_A = 12;
   localparam int unsigned SHIFT_B = 25;
   localparam int unsigned SHIFT_C = 27;

   typedef enum logic [ACTION_W-1:0] {
      ACT_RAW64   = 2'd0,
      ACT_RAW32   = 2'd1,
      ACT_UNIFORM = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   // Handshake between the sequencer and a multi-cycle arithmetic unit.
   typedef struct packed {
      logic start;
   } unit_cmd_type;

   typedef struct packed {
      logic done;
   } unit_sts_type;

   function automatic logic [WORD_W-1:0] xorshift_step(input logic [WORD_W-1:0] s);
      logic [WORD_W-1:0] x;
      x = s;
      x = x ^ (x >> SHIFT_A);
      x = x ^ (x << SHIFT_B);
      x = x ^ (x >> SHIFT_C);
      return x;
   endfunction

endpackage

>>> rtl/xbrs_if.sv
// Request and response channel interfaces of the bounded random source.
`timescale 1ns / 1ps
interface xbrs_req_if;
   import xbrs_pkg::*;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [BOUND_W-1:0]  bound;

   modport source (output valid, output action, output bound, input ready);
   modport sink   (input valid, input action, input bound, output ready);
endinterface

interface xbrs_rsp_if;
   import xbrs_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

>>> rtl/xbrs_mul.sv
// Three-pass scrambling multiplier: low 64 bits of a times the scramble constant.
`timescale 1ns / 1ps
module xbrs_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  xbrs_pkg::unit_cmd_type       cmd,
   input  logic [xbrs_pkg::WORD_W-1:0]  operand,
   output xbrs_pkg::unit_sts_type       sts,
   output logic [xbrs_pkg::WORD_W-1:0]  product
);
   import xbrs_pkg::*;

   localparam logic [HALF_W-1:0] MUL_LO = SCRAMBLE_MUL[HALF_W-1:0];
   localparam logic [HALF_W-1:0] MUL_HI = SCRAMBLE_MUL[WORD_W-1:HALF_W];

   logic [WORD_W-1:0] a_ff;
   logic [WORD_W-1:0] acc_ff;
   logic [WORD_W-1:0] acc_in;
   logic [1:0]        pass_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [HALF_W-1:0] op_x;
   logic [HALF_W-1:0] op_y;
   logic [WORD_W-1:0] part;

   // lo*lo first, then both cross terms into the upper half
   always_comb begin
      op_x   = (pass_ff == 2'd2) ? a_ff[WORD_W-1:HALF_W] : a_ff[HALF_W-1:0];
      op_y   = (pass_ff == 2'd1) ? MUL_HI : MUL_LO;
      part   = WORD_W'(op_x) * WORD_W'(op_y);
      acc_in = acc_ff;
      if (pass_ff == 2'd0) begin
         acc_in = part;
      end else begin
         acc_in[WORD_W-1:HALF_W] = acc_ff[WORD_W-1:HALF_W] + part[HALF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         pass_ff <= 2'd0;
      end else begin
         done_ff <= busy_ff && (pass_ff == 2'd2);
         if (cmd.start) begin
            busy_ff <= 1'b1;
            pass_ff <= 2'd0;
            a_ff    <= operand;
         end else if (busy_ff) begin
            acc_ff  <= acc_in;
            pass_ff <= pass_ff + 2'd1;
            if (pass_ff == 2'd2) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign sts.done = done_ff;
   assign product  = acc_ff;

endmodule

>>> rtl/xbrs_div.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps
module xbrs_div (
   input  logic                         clock,
   input  logic                         reset,
   input  xbrs_pkg::unit_cmd_type       cmd,
   input  logic [xbrs_pkg::HALF_W-1:0]  dividend,
   input  logic [xbrs_pkg::HALF_W-1:0]  divisor,
   output xbrs_pkg::unit_sts_type       sts,
   output logic [xbrs_pkg::HALF_W-1:0]  remainder
);
   import xbrs_pkg::*;

   localparam int unsigned CNT_W = $clog2(HALF_W);

   logic [HALF_W-1:0] rem_ff;
   logic [HALF_W-1:0] rem_in;
   logic [HALF_W-1:0] dvd_ff;
   logic [HALF_W-1:0] dsr_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [HALF_W:0]   trial;
   logic [HALF_W:0]   diff;

   always_comb begin
      trial  = {rem_ff, dvd_ff[HALF_W-1]};
      diff   = trial - {1'b0, dsr_ff};
      rem_in = diff[HALF_W] ? trial[HALF_W-1:0] : diff[HALF_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNT_W'(HALF_W - 1));
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            dvd_ff  <= dividend;
            dsr_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= dvd_ff << 1;
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(HALF_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign sts.done  = done_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/xorshift_bounded_random_source.sv
// Top level: xorshift64* source with rejection-sampled bounded output.
//
//   channel   direction  handshake                contents
//   req_chan  in         valid/ready              action, bound
//   rsp_chan  out        valid/ready              value (one word per request)
//   psel..    in         APB write, pready high   seed at byte address 0
//
// A raw 64- or 32-bit request passes through the accept cycle, one xorshift step,
// three passes through the single 32x32 multiplier, its done flag and the load of
// the response register. A uniform request adds a threshold remainder in the serial
// divider and, per accepted draw, another remainder in that divider; every rejected
// draw repeats the step and the multiply. Zero bound or unused action: no arithmetic.
// Reset is synchronous and loads the fixed start state; a stalled response word
// holds in its register and the next request may be taken meanwhile.
`timescale 1ns / 1ps
module xorshift_bounded_random_source (
   input  logic        clock,
   input  logic        reset,
   xbrs_req_if.sink    req_chan,
   xbrs_rsp_if.source  rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   import xbrs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_THR,
      ST_DRAW,
      ST_MUL,
      ST_MOD,
      ST_DONE
   } state_type;

   state_type         state_ff;
   logic [WORD_W-1:0] seed_ff;
   logic [WORD_W-1:0] gen_state_ff;
   logic [WORD_W-1:0] gen_next;
   action_type        action_ff;
   logic [BOUND_W-1:0] bound_ff;
   logic [HALF_W-1:0] thr_ff;
   logic [WORD_W-1:0] result_ff;
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_value_ff;

   logic              req_take;
   logic              csr_write;
   action_type        req_action;
   unit_cmd_type      mul_cmd;
   unit_sts_type      mul_sts;
   logic [WORD_W-1:0] mul_product;
   unit_cmd_type      div_cmd;
   unit_sts_type      div_sts;
   logic [HALF_W-1:0] div_dividend;
   logic [HALF_W-1:0] div_divisor;
   logic [HALF_W-1:0] div_rem;
   logic [HALF_W-1:0] draw_low;
   logic              draw_keep;

   // configuration: one 64-bit seed register, pready tied high
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[3] == 1'b0);
   assign prdata    = (paddr[3] == 1'b0) ? seed_ff : '0;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign req_action     = action_type'(req_chan.action);

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.value = rsp_value_ff;

   assign gen_next  = xorshift_step(gen_state_ff);
   assign draw_low  = mul_product[HALF_W-1:0];
   assign draw_keep = (draw_low >= thr_ff);

   // multiplier takes the freshly stepped state
   assign mul_cmd.start = (state_ff == ST_DRAW);

   // divider: threshold (2^32 - bound) mod bound on accept, then draw mod bound
   always_comb begin
      div_cmd.start = 1'b0;
      div_dividend  = draw_low;
      div_divisor   = bound_ff;
      if (state_ff == ST_IDLE) begin
         div_dividend  = HALF_W'(0) - req_chan.bound;
         div_divisor   = req_chan.bound;
         div_cmd.start = req_take && (req_action == ACT_UNIFORM) && (req_chan.bound != '0);
      end else if (state_ff == ST_MUL) begin
         div_cmd.start = mul_sts.done && (action_ff == ACT_UNIFORM) && draw_keep;
      end
   end

   xbrs_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mul_cmd),
      .operand (gen_next),
      .sts     (mul_sts),
      .product (mul_product)
   );

   xbrs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .sts       (div_sts),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= '0;
         gen_state_ff <= RESET_STATE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a finished word when the register is free, drop it once taken
         if ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // seed write: zero seed falls back to a fixed nonzero state
         if (csr_write) begin
            seed_ff      <= pwdata;
            gen_state_ff <= (pwdata != '0) ? pwdata : SEED_FALLBACK;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  action_ff <= req_action;
                  bound_ff  <= req_chan.bound;
                  result_ff <= '0;
                  case (req_action)
                     ACT_RAW64, ACT_RAW32: state_ff <= ST_DRAW;
                     ACT_UNIFORM: begin
                        state_ff <= (req_chan.bound != '0) ? ST_THR : ST_DONE;
                     end
                     default: state_ff <= ST_DONE;
                  endcase
               end
            end
            ST_THR: begin
               if (div_sts.done) begin
                  thr_ff   <= div_rem;
                  state_ff <= ST_DRAW;
               end
            end
            ST_DRAW: begin
               // advance the generator; the multiplier latches the same value
               gen_state_ff <= gen_next;
               state_ff     <= ST_MUL;
            end
            ST_MUL: begin
               if (mul_sts.done) begin
                  case (action_ff)
                     ACT_RAW64: begin
                        result_ff <= mul_product;
                        state_ff  <= ST_DONE;
                     end
                     ACT_RAW32: begin
                        result_ff <= {{(WORD_W-HALF_W){1'b0}}, draw_low};
                        state_ff  <= ST_DONE;
                     end
                     default: begin
                        // reject draws below the threshold and draw again
                        state_ff <= draw_keep ? ST_MOD : ST_DRAW;
                     end
                  endcase
               end
            end
            ST_MOD: begin
               if (div_sts.done) begin
                  result_ff <= {{(WORD_W-HALF_W){1'b0}}, div_rem};
                  state_ff  <= ST_DONE;
               end
            end
            ST_DONE: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_value_ff <= result_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_chan.ready)
      else $error("request taken while previous one still in work");

   a_state_nonzero: assert property (@(posedge clock) disable iff (reset)
      gen_state_ff != '0)
      else $error("generator state reached zero");

   a_mul_done_place: assert property (@(posedge clock) disable iff (reset)
      mul_sts.done |-> state_ff == ST_MUL)
      else $error("multiplier finished outside its wait state");

   a_div_done_place: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == ST_THR || state_ff == ST_MOD))
      else $error("divider finished outside its wait states");

   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> div_rem < bound_ff)
      else $error("remainder not below bound");

endmodule

>>> verif/xorshift_bounded_random_source_test.sv
// Self-checking testbench for the xorshift64* bounded random source.
`timescale 1ns / 1ps
module xorshift_bounded_random_source_test;
   import xbrs_pkg::*;

   // Generator constants, kept independent of the package so a wrong
   // constant there shows up as a mismatch here.
   localparam logic [63:0] START_WORD    = 64'h0DEA_DCA7_FEED_BEEF;
   localparam logic [63:0] ZERO_SEED_SUB = 64'hCAFE_BABE_DEAD_BEEF;
   localparam logic [63:0] OUT_MULT      = 64'h2545_F491_4F6C_DD1D;
   localparam logic [3:0]  SEED_ADDR     = 4'd0;

   // Predicts every word the source returns and checks the words seen on the
   // response channel in order.
   class uniform_draw_scoreboard;
      logic [63:0] gen_word;
      logic [63:0] pending_words[$];
      int unsigned failures;

      function new();
         gen_word = START_WORD;
         failures = 0;
      endfunction

      function void load_seed(input logic [63:0] seed_val);
         gen_word = (seed_val != 64'd0) ? seed_val : ZERO_SEED_SUB;
      endfunction

      // Advance the xorshift state and return the scrambled word.
      function logic [63:0] next_draw();
         logic [63:0] x;
         x = gen_word;
         x = x ^ (x >> 12);
         x = x ^ (x << 25);
         x = x ^ (x >> 27);
         gen_word = x;
         return x * OUT_MULT;
      endfunction

      function void note_request(input action_type act, input logic [31:0] bnd);
         logic [63:0] d;
         logic [31:0] cutoff;
         logic [31:0] low_half;
         logic [63:0] word_out;
         case (act)
            ACT_RAW64: begin
               word_out = next_draw();
            end
            ACT_RAW32: begin
               d = next_draw();
               word_out = {32'd0, d[31:0]};
            end
            ACT_UNIFORM: begin
               if (bnd == 32'd0) begin
                  word_out = 64'd0;
               end else begin
                  // Reject low halves below (2^32 - bound) mod bound.
                  cutoff = (32'd0 - bnd) % bnd;
                  do begin
                     d = next_draw();
                     low_half = d[31:0];
                  end while (low_half < cutoff);
                  word_out = {32'd0, low_half % bnd};
               end
            end
            default: begin
               word_out = 64'd0;
            end
         endcase
         pending_words.push_back(word_out);
      endfunction

      function void check_value(input logic [63:0] got);
         logic [63:0] want;
         if (pending_words.size() == 0) begin
            $error("value: no word expected, got %h", got);
            failures++;
         end else begin
            want = pending_words.pop_front();
            if (got !== want) begin
               $error("value: expected %h, got %h", want, got);
               failures++;
            end
         end
      endfunction

      function int unsigned outstanding();
         return pending_words.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;

   xbrs_req_if req_if ();
   xbrs_rsp_if rsp_if ();

   uniform_draw_scoreboard sb;

   // Idle rates in percent for the two sides of the block.
   int unsigned send_gap_pct;
   int unsigned recv_stall_pct;

   xorshift_bounded_random_source i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Response side: check each accepted word, then pick the next ready level.
   // Values read here are the ones from before the edge, since the block
   // updates its outputs with nonblocking assignments.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_value(rsp_if.value);
         end
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Offer one request word, idling first at the current gap rate. Return in
   // the time step of the edge that accepted it, so the next call may keep
   // valid high without lowering it.
   task automatic push_request(input action_type act, input logic [31:0] bnd);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.action <= act;
      req_if.bound  <= bnd;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_request(act, bnd);
   endtask

   // Drop valid and hold until every predicted word has come back.
   task automatic drain_responses();
      req_if.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Write the seed, then read it straight back. psel stays high from the
   // write's access cycle into the read's setup cycle.
   task automatic write_seed(input logic [63:0] seed_val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= SEED_ADDR;
      pwdata  <= seed_val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.load_seed(seed_val);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== seed_val) begin
         $error("seed: expected %h, got %h", seed_val, prdata);
         sb.failures++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic action_type pick_action();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return ACT_RAW64;
      if (roll < 50) return ACT_RAW32;
      if (roll < 95) return ACT_UNIFORM;
      return ACT_NONE;
   endfunction

   // Bias bounds towards the interesting corners: zero, tiny, powers of two,
   // values just past half range (heavy rejection) and the very top.
   function automatic logic [31:0] pick_bound();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return $urandom_range(1, 16);
         2: return 32'd1 << $urandom_range(0, 31);
         3: return 32'hFFFF_FFFF - $urandom_range(0, 15);
         4: return 32'h8000_0000 + $urandom_range(0, 15);
         5: return $urandom_range(1, 1000);
         default: return $urandom();
      endcase
   endfunction

   // Random words; every so often hold the sender until the block is empty.
   task automatic run_random(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         push_request(pick_action(), pick_bound());
         if (i % 150 == 149) begin
            drain_responses();
         end
      end
   endtask

   initial begin
      sb = new();
      send_gap_pct   = 31;
      recv_stall_pct = 45;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.action  <= ACT_NONE;
      req_if.bound   <= 32'd0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= SEED_ADDR;
      pwdata         <= 64'd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed words from the reset state: field extremes, every action,
      // zero bound, the unused action, bound ignored on raw draws, and
      // bounds that force frequent rejection.
      push_request(ACT_RAW64,   32'd0);
      push_request(ACT_RAW64,   32'hFFFF_FFFF);
      push_request(ACT_RAW32,   32'd0);
      push_request(ACT_RAW32,   32'hFFFF_FFFF);
      push_request(ACT_UNIFORM, 32'd0);
      push_request(ACT_UNIFORM, 32'd1);
      push_request(ACT_UNIFORM, 32'd2);
      push_request(ACT_UNIFORM, 32'd3);
      push_request(ACT_UNIFORM, 32'hFFFF_FFFF);
      push_request(ACT_UNIFORM, 32'h8000_0000);
      push_request(ACT_UNIFORM, 32'h8000_0001);
      push_request(ACT_UNIFORM, 32'h7FFF_FFFF);
      push_request(ACT_UNIFORM, 32'hAAAA_AAAA);
      push_request(ACT_UNIFORM, 32'h5555_5555);
      push_request(ACT_UNIFORM, 32'hC000_0001);
      push_request(ACT_NONE,    32'd0);
      push_request(ACT_NONE,    32'hFFFF_FFFF);
      push_request(ACT_RAW64,   32'h1234_5678);
      push_request(ACT_UNIFORM, 32'd6);
      push_request(ACT_UNIFORM, 32'd0);
      push_request(ACT_RAW32,   32'hDEAD_0001);
      push_request(ACT_NONE,    32'd3);
      push_request(ACT_RAW64,   32'd0);
      drain_responses();

      // Zero seed must select the fallback state.
      write_seed(64'd0);
      send_gap_pct   = 31;
      recv_stall_pct = 45;
      run_random(560);
      drain_responses();

      write_seed(64'hFFFF_FFFF_FFFF_FFFF);
      send_gap_pct   = 45;
      recv_stall_pct = 31;
      run_random(560);
      drain_responses();

      write_seed({$urandom(), $urandom()});
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      run_random(290);
      drain_responses();

      write_seed(64'd1);
      run_random(290);
      drain_responses();

      // Wait for any stray word beyond the last expected one.
      repeat (100) @(posedge clock);
      if (sb.outstanding() != 0) begin
         $error("value: %0d expected words never arrived", sb.outstanding());
         sb.failures++;
      end
      if (sb.failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Safety net against a hung handshake.
   initial begin
      #(12 * 3_000_000);
      $display("Mismatches found");
      $finish;
   end

endmodule
